// File: design/rtc_pkg.sv
// Shared constants and types for the rectangle tiling check.
package rtc_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COORD_BITS_DEF = 16;
	localparam int AREA_BITS = 48;
	localparam int CORNERS = 4;
	localparam int SEEN_BITS = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T0,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_SWEEP,
		ST_BOX,
		ST_MUL,
		ST_RESULT
	} rtc_state_t;

	typedef struct packed {
		logic toggle;
		logic sweep;
	} rtc_cmd_t;

	typedef struct packed {
		logic any_hit;
		logic full;
	} rtc_status_t;

endpackage

// File: design/rtc_cell.sv
// One corner cell: holds a packed corner and its valid bit, shifts toward the tail on a sweep.
module rtc_cell
	import rtc_pkg::*;
#(
	parameter int KEY_BITS = 2 * COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rtc_cmd_t            cmd,
	input  logic [KEY_BITS-1:0] key,
	input  logic                any_hit,
	input  logic                claim_in,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic                prev_valid,
	output logic                hit,
	output logic                claim_out,
	output logic [KEY_BITS-1:0] key_q,
	output logic                valid_q
);

	logic insert;

	assign hit = valid_q && (key_q == key);
	assign claim_out = claim_in || !valid_q;
	assign insert = cmd.toggle && !any_hit && !valid_q && !claim_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.sweep) begin
			valid_q <= prev_valid;
		end else if (cmd.toggle && hit) begin
			valid_q <= 1'b0;
		end else if (insert) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			key_q <= prev_key;
		end else if (insert) begin
			key_q <= key;
		end
	end

endmodule

// File: design/rtc_table.sv
// Corner table: a chain of corner cells with a free-slot claim chain and a hit reduction.
module rtc_table
	import rtc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS = 2 * COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rtc_cmd_t            cmd,
	input  logic [KEY_BITS-1:0] key,
	output rtc_status_t         status,
	output logic [KEY_BITS-1:0] tail_key,
	output logic                tail_valid
);

	logic [TABLE_DEPTH-1:0] hit;
	logic [TABLE_DEPTH:0]   claim;
	logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_valid;
	logic                   any_hit;

	assign claim[0] = 1'b0;
	assign any_hit = |hit;

	genvar i;
	generate
		for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_head
				rtc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd), .key(key),
					.any_hit(any_hit), .claim_in(claim[i]),
					.prev_key({KEY_BITS{1'b0}}), .prev_valid(1'b0),
					.hit(hit[i]), .claim_out(claim[i+1]),
					.key_q(cell_key[i]), .valid_q(cell_valid[i])
				);
			end else begin : g_body
				rtc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd), .key(key),
					.any_hit(any_hit), .claim_in(claim[i]),
					.prev_key(cell_key[i-1]), .prev_valid(cell_valid[i-1]),
					.hit(hit[i]), .claim_out(claim[i+1]),
					.key_q(cell_key[i]), .valid_q(cell_valid[i])
				);
			end
		end
	endgenerate

	assign status.any_hit = any_hit;
	assign status.full = !claim[TABLE_DEPTH];
	assign tail_key = cell_key[TABLE_DEPTH-1];
	assign tail_valid = cell_valid[TABLE_DEPTH-1];

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.toggle |-> $onehot0(hit))
		else $error("corner stored in more than one cell");

	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> (&cell_valid))
		else $error("table reported full with a free cell");

	a_sweep_drains: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |=> !cell_valid[0])
		else $error("head cell still valid after a sweep shift");

endmodule

// File: design/rtc_area.sv
// Area accumulator: registered rectangle area, then a checked add into the 48-bit sum.
module rtc_area
	import rtc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        clear,
	input  logic [COORD_BITS-1:0]       x_left,
	input  logic [COORD_BITS-1:0]       y_bottom,
	input  logic [COORD_BITS-1:0]       x_right,
	input  logic [COORD_BITS-1:0]       y_top,
	output logic                        ovf,
	output logic signed [AREA_BITS-1:0] total_q
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int EW = (PW > AREA_BITS) ? PW : AREA_BITS + 1;

	logic signed [DW-1:0]        dx;
	logic signed [DW-1:0]        dy;
	logic signed [PW-1:0]        prod_s1;
	logic                        valid_s1;
	logic signed [EW-1:0]        ext;
	logic signed [AREA_BITS-1:0] area;
	logic                        area_ovf;
	logic [AREA_BITS:0]          sum;
	logic                        sum_ovf;

	assign dx = {x_right[COORD_BITS-1], x_right} - {x_left[COORD_BITS-1], x_left};
	assign dy = {y_top[COORD_BITS-1], y_top} - {y_bottom[COORD_BITS-1], y_bottom};

	always_ff @(posedge clk) begin
		prod_s1 <= dx * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	assign ext = EW'(prod_s1);
	assign area = ext[AREA_BITS-1:0];
	assign area_ovf = ext != EW'(area);
	assign sum = {total_q[AREA_BITS-1], total_q} + {area[AREA_BITS-1], area};
	assign sum_ovf = sum[AREA_BITS] != sum[AREA_BITS-1];
	assign ovf = valid_s1 && (area_ovf || sum_ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (clear) begin
			total_q <= '0;
		end else if (valid_s1 && !ovf) begin
			total_q <= sum[AREA_BITS-1:0];
		end
	end

endmodule

// File: design/rectangle_tiling_check.sv
// Rectangle tiling check: toggles corners in a cell chain and checks the cover on the last item.
//
// Input channel (in_valid/in_ready): one rectangle per transfer, given as signed
// x_left, y_bottom, x_right, y_top and a last marker closing the set.
// Output channel (out_valid/out_ready): one transfer per set, carrying covers
// (the set tiles one rectangle exactly) and error (corner table or area sum overflowed).
// Each rectangle's four corners go to the corner chain one per cycle, each a parallel
// compare across all cells with a free-slot claim chain, and the next rectangle is
// taken in the cycle of the fourth corner.
// After a last rectangle the chain shifts its contents out toward the tail, which also
// empties it, then the ST_BOX, ST_MUL and ST_RESULT states form the bounding box,
// multiply it out and compare with the sum; no input is taken from the last transfer
// until the set's result is loaded.
// A result waits in the output register while the receiver stalls; input is still
// taken until the next result must be loaded.
// Reset empties the corner table, clears the sum and error state, and drops any result.
module rectangle_tiling_check
	import rtc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] x_left,
	input  logic [COORD_BITS-1:0] y_bottom,
	input  logic [COORD_BITS-1:0] x_right,
	input  logic [COORD_BITS-1:0] y_top,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  covers,
	output logic                  error
);

	localparam int KEY_BITS = 2 * COORD_BITS;
	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int CW = (2 * COORD_BITS > AREA_BITS) ? 2 * COORD_BITS : AREA_BITS;

	rtc_state_t                  state_q;
	rtc_state_t                  state_d;
	rtc_cmd_t                    cmd;
	rtc_status_t                 status;
	logic [KEY_BITS-1:0]         key;
	logic [KEY_BITS-1:0]         tail_key;
	logic                        tail_valid;
	logic                        area_start;
	logic                        area_ovf;
	logic signed [AREA_BITS-1:0] total;
	logic                        done;
	logic                        take;

	logic [COORD_BITS-1:0]       xl_q;
	logic [COORD_BITS-1:0]       yb_q;
	logic [COORD_BITS-1:0]       xr_q;
	logic [COORD_BITS-1:0]       yt_q;
	logic                        last_q;
	logic                        ovf_q;
	logic [SW-1:0]               sweep_q;
	logic [SEEN_BITS-1:0]        seen_q;
	logic [KEY_BITS-1:0]         corner_q [CORNERS];

	logic signed [COORD_BITS-1:0] xmin;
	logic signed [COORD_BITS-1:0] xmax;
	logic signed [COORD_BITS-1:0] ymin;
	logic signed [COORD_BITS-1:0] ymax;
	logic                         on_box;
	logic [COORD_BITS:0]          wdiff;
	logic [COORD_BITS:0]          hdiff;
	logic [COORD_BITS-1:0]        w_s1;
	logic [COORD_BITS-1:0]        h_s1;
	logic                         box_ok_s1;
	logic [2*COORD_BITS-1:0]      wh_s2;
	logic                         cover_ok;

	logic                         out_valid_q;
	logic                         covers_q;
	logic                         error_q;

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		key = {xr_q, yb_q};
		area_start = 1'b0;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_T0;
			end
			ST_T0: begin
				cmd.toggle = 1'b1;
				key = {xr_q, yb_q};
				area_start = 1'b1;
				state_d = ST_T1;
			end
			ST_T1: begin
				cmd.toggle = 1'b1;
				key = {xr_q, yt_q};
				state_d = ST_T2;
			end
			ST_T2: begin
				cmd.toggle = 1'b1;
				key = {xl_q, yt_q};
				state_d = ST_T3;
			end
			ST_T3: begin
				cmd.toggle = 1'b1;
				key = {xl_q, yb_q};
				if (last_q) begin
					state_d = ST_SWEEP;
				end else begin
					in_ready = 1'b1;
					state_d = in_valid ? ST_T0 : ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sweep_q == SW'(TABLE_DEPTH - 1)) state_d = ST_BOX;
			end
			ST_BOX: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			xl_q <= x_left;
			yb_q <= y_bottom;
			xr_q <= x_right;
			yt_q <= y_top;
			last_q <= last;
		end
	end

	rtc_table #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_table (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .key(key), .status(status),
		.tail_key(tail_key), .tail_valid(tail_valid)
	);

	rtc_area #(.COORD_BITS(COORD_BITS)) u_area (
		.clk(clk), .arst_n(arst_n), .start(area_start), .clear(done),
		.x_left(xl_q), .y_bottom(yb_q), .x_right(xr_q), .y_top(yt_q),
		.ovf(area_ovf), .total_q(total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (done) begin
			ovf_q <= 1'b0;
		end else if (area_ovf || (cmd.toggle && !status.any_hit && status.full)) begin
			ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			seen_q <= '0;
		end else begin
			if (cmd.sweep) begin
				sweep_q <= (sweep_q == SW'(TABLE_DEPTH - 1)) ? '0 : sweep_q + 1'b1;
			end
			if (done) begin
				seen_q <= '0;
			end else if (cmd.sweep && tail_valid && seen_q <= SEEN_BITS'(CORNERS)) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep && tail_valid && seen_q < SEEN_BITS'(CORNERS)) begin
			corner_q[seen_q[1:0]] <= tail_key;
		end
	end

	always_comb begin
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		xmin = corner_q[0][KEY_BITS-1:COORD_BITS];
		xmax = corner_q[0][KEY_BITS-1:COORD_BITS];
		ymin = corner_q[0][COORD_BITS-1:0];
		ymax = corner_q[0][COORD_BITS-1:0];
		for (int i = 1; i < CORNERS; i++) begin
			cx = corner_q[i][KEY_BITS-1:COORD_BITS];
			cy = corner_q[i][COORD_BITS-1:0];
			if (cx < xmin) xmin = cx;
			if (cx > xmax) xmax = cx;
			if (cy < ymin) ymin = cy;
			if (cy > ymax) ymax = cy;
		end
		on_box = 1'b1;
		for (int i = 0; i < CORNERS; i++) begin
			cx = corner_q[i][KEY_BITS-1:COORD_BITS];
			cy = corner_q[i][COORD_BITS-1:0];
			if ((cx != xmin && cx != xmax) || (cy != ymin && cy != ymax)) on_box = 1'b0;
		end
	end

	assign wdiff = {xmax[COORD_BITS-1], xmax} - {xmin[COORD_BITS-1], xmin};
	assign hdiff = {ymax[COORD_BITS-1], ymax} - {ymin[COORD_BITS-1], ymin};

	always_ff @(posedge clk) begin
		if (state_q == ST_BOX) begin
			w_s1 <= wdiff[COORD_BITS-1:0];
			h_s1 <= hdiff[COORD_BITS-1:0];
			box_ok_s1 <= on_box;
		end
		if (state_q == ST_MUL) begin
			wh_s2 <= w_s1 * h_s1;
		end
	end

	assign cover_ok = box_ok_s1 && (seen_q == SEEN_BITS'(CORNERS)) && !ovf_q
		&& !total[AREA_BITS-1]
		&& (CW'(wh_s2) == CW'(unsigned'(total)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			covers_q <= cover_ok;
			error_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign covers = covers_q;
	assign error = error_q;

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(covers_q && error_q))
		else $error("covers and error raised together");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not held after load");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && sweep_q == SW'(TABLE_DEPTH - 1)) |=> state_q == ST_BOX)
		else $error("sweep did not end after one pass");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_BITS'(CORNERS + 1))
		else $error("corner tally out of range");

endmodule

// File: tb/sv/rectangle_tiling_check_tb.sv
// Self-checking testbench for the rectangle tiling check, with its own cover predictor.
module rectangle_tiling_check_tb;
	import rtc_pkg::*;

	typedef struct {
		logic signed [COORD_BITS_DEF-1:0] xl;
		logic signed [COORD_BITS_DEF-1:0] yb;
		logic signed [COORD_BITS_DEF-1:0] xr;
		logic signed [COORD_BITS_DEF-1:0] yt;
		logic                             fin;
	} rect_t;

	typedef struct {
		logic covers;
		logic err;
	} verdict_t;

	localparam longint AREA_LIM = longint'(1) << (AREA_BITS - 1);

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic signed [COORD_BITS_DEF-1:0] x_left;
	logic signed [COORD_BITS_DEF-1:0] y_bottom;
	logic signed [COORD_BITS_DEF-1:0] x_right;
	logic signed [COORD_BITS_DEF-1:0] y_top;
	logic                             last;
	logic                             out_valid;
	logic                             out_ready;
	logic                             covers;
	logic                             error;

	rect_t    pending_rects[$];
	verdict_t verdict_q[$];

	bit       open_corners[bit [2*COORD_BITS_DEF-1:0]];
	longint   area_acc;
	bit       spilled;

	int       mismatches;
	int       n_taken;
	int       n_results;
	int       n_tiled;
	int       n_spilled;
	int       pressure_at;
	bit       hold_rx;
	bit       in_sent;
	bit       out_sent;
	int       tx_gap;
	int       rx_gap;
	int       tx_run;
	int       rx_run;

	rectangle_tiling_check uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x_left   (x_left),
		.y_bottom (y_bottom),
		.x_right  (x_right),
		.y_top    (y_top),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.covers   (covers),
		.error    (error)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int pick_gap(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run = 30;
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic void flip_corner(input logic [COORD_BITS_DEF-1:0] cx,
					    input logic [COORD_BITS_DEF-1:0] cy);
		bit [2*COORD_BITS_DEF-1:0] key;
		key = {cx, cy};
		if (open_corners.exists(key))
			open_corners.delete(key);
		else if (open_corners.num() >= TABLE_DEPTH_DEF)
			spilled = 1'b1;
		else
			open_corners[key] = 1'b1;
	endfunction

	function automatic bit tiles_exactly();
		logic signed [COORD_BITS_DEF-1:0] sx;
		logic signed [COORD_BITS_DEF-1:0] sy;
		int xmin, xmax, ymin, ymax;
		bit first;
		first = 1'b1;
		xmin = 0;
		xmax = 0;
		ymin = 0;
		ymax = 0;
		if (spilled || open_corners.num() != CORNERS)
			return 1'b0;
		foreach (open_corners[key]) begin
			sx = key[2*COORD_BITS_DEF-1:COORD_BITS_DEF];
			sy = key[COORD_BITS_DEF-1:0];
			if (first || sx < xmin) xmin = sx;
			if (first || sx > xmax) xmax = sx;
			if (first || sy < ymin) ymin = sy;
			if (first || sy > ymax) ymax = sy;
			first = 1'b0;
		end
		foreach (open_corners[key]) begin
			sx = key[2*COORD_BITS_DEF-1:COORD_BITS_DEF];
			sy = key[COORD_BITS_DEF-1:0];
			if ((sx != xmin && sx != xmax) || (sy != ymin && sy != ymax))
				return 1'b0;
		end
		if (area_acc < 0)
			return 1'b0;
		return longint'(xmax - xmin) * longint'(ymax - ymin) == area_acc;
	endfunction

	function automatic void fold_rect(input rect_t r);
		longint dx, dy, ar, nsum;
		dx = longint'(r.xr) - longint'(r.xl);
		dy = longint'(r.yt) - longint'(r.yb);
		ar = dx * dy;
		if (ar >= AREA_LIM || ar < -AREA_LIM) begin
			spilled = 1'b1;
		end else begin
			nsum = area_acc + ar;
			if (nsum >= AREA_LIM || nsum < -AREA_LIM)
				spilled = 1'b1;
			else
				area_acc = nsum;
		end
		flip_corner(r.xr, r.yb);
		flip_corner(r.xr, r.yt);
		flip_corner(r.xl, r.yt);
		flip_corner(r.xl, r.yb);
		if (r.fin) begin
			verdict_q.push_back('{covers: tiles_exactly(), err: spilled});
			open_corners.delete();
			area_acc = 0;
			spilled = 1'b0;
		end
	endfunction

	function automatic void push_rect(input int xl, input int yb, input int xr, input int yt,
					  input bit fin);
		rect_t r;
		r.xl = COORD_BITS_DEF'(xl);
		r.yb = COORD_BITS_DEF'(yb);
		r.xr = COORD_BITS_DEF'(xr);
		r.yt = COORD_BITS_DEF'(yt);
		r.fin = fin;
		pending_rects.push_back(r);
	endfunction

	// sample both channels
	always @(posedge clk) begin
		rect_t r;
		verdict_t v;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				r.xl = x_left;
				r.yb = y_bottom;
				r.xr = x_right;
				r.yt = y_top;
				r.fin = last;
				fold_rect(r);
				n_taken++;
				in_sent = 1'b1;
			end
			if (out_valid && out_ready) begin
				out_sent = 1'b1;
				n_results++;
				if (verdict_q.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					v = verdict_q.pop_front();
					if (covers !== v.covers)
						report_mismatch($sformatf("covers %b, expected %b",
							covers, v.covers));
					if (error !== v.err)
						report_mismatch($sformatf("error %b, expected %b",
							error, v.err));
					if (covers === 1'b1) n_tiled++;
					if (error === 1'b1) n_spilled++;
				end
			end
		end
	end

	// drive rectangles
	always @(negedge clk) begin
		rect_t r;
		logic nv;
		nv = in_valid;
		if (in_sent) begin
			in_sent = 1'b0;
			nv = 1'b0;
			tx_gap = pick_gap(tx_run);
		end
		if (!nv && arst_n) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_rects.size() > 0) begin
				r = pending_rects.pop_front();
				x_left <= r.xl;
				y_bottom <= r.yb;
				x_right <= r.xr;
				y_top <= r.yt;
				last <= r.fin;
				nv = 1'b1;
			end
		end
		in_valid <= nv;
	end

	// drive result acceptance
	always @(negedge clk) begin
		logic nr;
		nr = out_ready;
		if (out_sent) begin
			out_sent = 1'b0;
			nr = 1'b0;
			rx_gap = pick_gap(rx_run);
		end
		if (!nr && arst_n) begin
			if (rx_gap > 0)
				rx_gap--;
			else
				nr = 1'b1;
		end
		if (hold_rx)
			nr = 1'b0;
		out_ready <= nr;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		x_left = '0;
		y_bottom = '0;
		x_right = '0;
		y_top = '0;
		last = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// long receiver stall so the block fills up and blocks its input
	initial begin
		hold_rx = 1'b0;
		wait (pressure_at > 0 && n_taken >= pressure_at);
		@(posedge clk);
		hold_rx = 1'b1;
		repeat (800) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		int bx0[$], by0[$], bx1[$], by1[$];
		int lo_x, lo_y, span_x, span_y, pieces, j, k, cut, t, n, stop_at;
		mismatches = 0;
		n_taken = 0;
		n_results = 0;
		n_tiled = 0;
		n_spilled = 0;
		pressure_at = 0;
		in_sent = 1'b0;
		out_sent = 1'b0;
		tx_gap = 0;
		rx_gap = 0;
		tx_run = 0;
		rx_run = 0;
		area_acc = 0;
		spilled = 1'b0;

		push_rect(-32768, -32768, 32767, 32767, 1);
		push_rect(-32768, -32768, 0, 32767, 0);
		push_rect(0, -32768, 32767, 32767, 1);
		push_rect(10, 10, 0, 0, 1);
		push_rect(10, 0, 0, 5, 1);
		push_rect(5, 5, 5, 9, 0);
		push_rect(3, 3, 3, 3, 1);
		push_rect(0, 0, 4, 4, 0);
		push_rect(4, 0, 4, 4, 1);
		push_rect(0, 0, 2, 2, 0);
		push_rect(0, 0, 2, 2, 0);
		push_rect(0, 0, 2, 2, 1);
		for (j = 0; j < 17; j++)
			push_rect(j * 4, 0, j * 4 + 1, 1, j == 16);

		pressure_at = pending_rects.size() + 50;
		stop_at = pending_rects.size() + 1300;
		while (pending_rects.size() < stop_at) begin
			t = $urandom_range(0, 19);
			if (t < 14) begin
				lo_x = $urandom_range(0, 65535) - 32768;
				lo_y = $urandom_range(0, 65535) - 32768;
				case ($urandom_range(0, 3))
					0: span_x = 65535;
					1: span_x = $urandom_range(1, 8);
					2: span_x = $urandom_range(1, 300);
					default: span_x = $urandom_range(1, 65535);
				endcase
				case ($urandom_range(0, 3))
					0: span_y = 65535;
					1: span_y = $urandom_range(1, 8);
					2: span_y = $urandom_range(1, 300);
					default: span_y = $urandom_range(1, 65535);
				endcase
				if (lo_x + span_x > 32767) lo_x = 32767 - span_x;
				if (lo_y + span_y > 32767) lo_y = 32767 - span_y;
				bx0 = {lo_x};
				by0 = {lo_y};
				bx1 = {lo_x + span_x};
				by1 = {lo_y + span_y};
				pieces = $urandom_range(1, 12);
				for (j = 1; j < pieces; j++) begin
					k = $urandom_range(0, bx0.size() - 1);
					if (bx1[k] - bx0[k] >= 2 &&
					    (by1[k] - by0[k] < 2 || $urandom_range(0, 1) == 1)) begin
						cut = bx0[k] + $urandom_range(1, bx1[k] - bx0[k] - 1);
						bx0.push_back(cut);
						by0.push_back(by0[k]);
						bx1.push_back(bx1[k]);
						by1.push_back(by1[k]);
						bx1[k] = cut;
					end else if (by1[k] - by0[k] >= 2) begin
						cut = by0[k] + $urandom_range(1, by1[k] - by0[k] - 1);
						bx0.push_back(bx0[k]);
						by0.push_back(cut);
						bx1.push_back(bx1[k]);
						by1.push_back(by1[k]);
						by1[k] = cut;
					end
				end
				for (j = bx0.size() - 1; j > 0; j--) begin
					k = $urandom_range(0, j);
					n = bx0[j]; bx0[j] = bx0[k]; bx0[k] = n;
					n = by0[j]; by0[j] = by0[k]; by0[k] = n;
					n = bx1[j]; bx1[j] = bx1[k]; bx1[k] = n;
					n = by1[j]; by1[j] = by1[k]; by1[k] = n;
				end
				// break some tilings: gap, overlap, shift, flip, noise, zero-width sliver
				if ($urandom_range(0, 9) < 3) begin
					case ($urandom_range(0, 5))
						0: if (bx0.size() > 1) begin
							bx0.delete(0);
							by0.delete(0);
							bx1.delete(0);
							by1.delete(0);
						end
						1: begin
							bx0.push_back(bx0[0]);
							by0.push_back(by0[0]);
							bx1.push_back(bx1[0]);
							by1.push_back(by1[0]);
						end
						2: bx1[0] = (bx1[0] == 32767) ? bx1[0] - 1 : bx1[0] + 1;
						3: begin
							n = bx0[0];
							bx0[0] = bx1[0];
							bx1[0] = n;
						end
						4: begin
							bx0.push_back($urandom_range(0, 65535));
							by0.push_back($urandom_range(0, 65535));
							bx1.push_back($urandom_range(0, 65535));
							by1.push_back($urandom_range(0, 65535));
						end
						default: begin
							bx0.push_back(bx0[0]);
							by0.push_back($urandom_range(0, 65535));
							bx1.push_back(bx0[0]);
							by1.push_back($urandom_range(0, 65535));
						end
					endcase
				end
				for (j = 0; j < bx0.size(); j++)
					push_rect(bx0[j], by0[j], bx1[j], by1[j], j == bx0.size() - 1);
			end else begin
				if (t < 17)
					n = $urandom_range(1, 6);
				else if (t < 19)
					n = $urandom_range(14, 20);
				else
					n = 1;
				for (j = 0; j < n; j++)
					push_rect($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						j == n - 1);
			end
		end

		wait (pending_rects.size() == 0 && !in_valid);
		wait (verdict_q.size() == 0);
		repeat (TABLE_DEPTH_DEF + 20) @(posedge clk);
		$display("summary: %0d rectangles taken, %0d results checked", n_taken, n_results);
		$display("summary: %0d sets tiled exactly, %0d sets overflowed", n_tiled, n_spilled);
		if (mismatches == 0)
			$display("rectangle_tiling_check_tb: clean");
		else
			$display("rectangle_tiling_check_tb: errors");
		$finish;
	end

	initial begin
		#25000000;
		$display("timeout with %0d results still expected", verdict_q.size());
		$display("rectangle_tiling_check_tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
design/rtc_pkg.sv
design/rtc_cell.sv
design/rtc_table.sv
design/rtc_area.sv
design/rectangle_tiling_check.sv
tb/sv/rectangle_tiling_check_tb.sv
